### rtl/rss_pkg.sv
// Package for the random sample set core: beat types, operation and status codes.
// No dependencies; imported by rss_store, random_sample_set_core, rss_result_checker and testbench.
`default_nettype none

package rss_pkg;

   localparam int DATA_W       = 32;
   localparam int RAND_W       = 31;
   localparam int COUNT_W      = 7;
   localparam int CAPACITY_DEF = 64;

   // operation codes
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_DRAW   = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_NOT   = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   typedef struct packed {
      logic [1:0]               kind;
      logic signed [DATA_W-1:0] value;
      logic [RAND_W-1:0]        random_draw;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] picked_value;
      logic [COUNT_W-1:0]       element_count;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/random_sample_set_core.sv
// Random sample set core: insert / remove / random draw over a dense store.
// Insert and remove: linear scan over the occupied part, one store read per cycle,
//   then for a remove that hits, the last-entry move. Draw: 31-step restoring modulo,
//   then one store read; draw on an empty set and an unused kind finish straight from idle.
// One beat at a time; busy is high while an item is in work. Results are a one-cycle
// strobe that cannot be stalled. Synchronous reset empties the set; store contents stay.
`default_nettype none

module random_sample_set_core
   import rss_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int STEP_W = $clog2(RAND_W);

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_LAST_RD  = 3'd2;
   localparam logic [2:0] S_LAST_WR  = 3'd3;
   localparam logic [2:0] S_DIV      = 3'd4;
   localparam logic [2:0] S_PICK_RD  = 3'd5;
   localparam logic [2:0] S_PICK_OUT = 3'd6;

   // control state
   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // working registers of the current beat
   logic [1:0]        kind_ff, kind_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [RAND_W-1:0] rnd_ff, rnd_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [ADDR_W-1:0] hit_ff, hit_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   rsp_type           rsp_ff, rsp_in;

   // store port
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;

   // shared compare / subtract unit and helpers
   logic              issue;
   logic              hit;
   logic [CNT_W-1:0]  last_idx;
   logic [CNT_W-1:0]  prev_scan;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    trial_diff;
   logic              fin;
   logic [1:0]        fin_status;
   logic [DATA_W-1:0] fin_picked;

   rss_store #(
      .DEPTH  (CAPACITY),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   assign last_idx   = count_ff - 1'b1;
   assign prev_scan  = scan_ff - 1'b1;
   // scan: read issued while the pointer is inside the occupied part
   assign issue      = (scan_ff < count_ff);
   // data of the read issued last cycle matches the key
   assign hit        = rd_vld_ff && (rd_data == value_ff);
   // one restoring-division step: shift in next dividend bit, try subtract
   assign trial      = {rem_ff, rnd_ff[RAND_W-1]};
   assign trial_diff = trial - {1'b0, count_ff};

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_vld_in  = 1'b0;
      kind_in    = kind_ff;
      value_in   = value_ff;
      rnd_in     = rnd_ff;
      scan_in    = scan_ff;
      hit_in     = hit_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      rsp_in     = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = count_ff[ADDR_W-1:0];
      wr_data    = value_ff;
      rd_en      = 1'b0;
      rd_addr    = scan_ff[ADDR_W-1:0];
      fin        = 1'b0;
      fin_status = STATUS_NOT;
      fin_picked = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in  = req_item.kind;
               value_in = req_item.value;
               rnd_in   = req_item.random_draw;
               scan_in  = '0;
               rem_in   = '0;
               step_in  = '0;
               case (req_item.kind) inside
                  KIND_INSERT, KIND_REMOVE: begin
                     state_in = S_SCAN;
                  end
                  KIND_DRAW: begin
                     if (count_ff == '0) begin
                        fin        = 1'b1;
                        fin_status = STATUS_EMPTY;
                     end else begin
                        state_in = S_DIV;
                     end
                  end
                  default: begin
                     // unused kind code: no effect
                     fin        = 1'b1;
                     fin_status = STATUS_NOT;
                  end
               endcase
            end
         end

         S_SCAN: begin
            rd_en     = issue;
            rd_vld_in = issue;
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (hit) begin
               rd_en     = 1'b0;
               rd_vld_in = 1'b0;
               if (kind_ff == KIND_INSERT) begin
                  fin        = 1'b1;
                  fin_status = STATUS_NOT;
               end else begin
                  hit_in   = prev_scan[ADDR_W-1:0];
                  state_in = S_LAST_RD;
               end
            end else if (!issue && !rd_vld_ff) begin
               // whole occupied part searched, key absent
               fin = 1'b1;
               if (kind_ff == KIND_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     fin_status = STATUS_FULL;
                  end else begin
                     wr_en      = 1'b1;
                     count_in   = count_ff + 1'b1;
                     fin_status = STATUS_DONE;
                  end
               end else begin
                  fin_status = STATUS_NOT;
               end
            end
         end

         S_LAST_RD: begin
            rd_en    = 1'b1;
            rd_addr  = last_idx[ADDR_W-1:0];
            state_in = S_LAST_WR;
         end

         S_LAST_WR: begin
            // move last entry into the freed slot
            wr_en      = 1'b1;
            wr_addr    = hit_ff;
            wr_data    = rd_data;
            count_in   = last_idx;
            fin        = 1'b1;
            fin_status = STATUS_DONE;
         end

         S_DIV: begin
            if (trial >= {1'b0, count_ff}) begin
               rem_in = trial_diff[CNT_W-1:0];
            end else begin
               rem_in = trial[CNT_W-1:0];
            end
            rnd_in  = rnd_ff << 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(RAND_W - 1)) begin
               state_in = S_PICK_RD;
            end
         end

         S_PICK_RD: begin
            rd_en    = 1'b1;
            rd_addr  = rem_ff[ADDR_W-1:0];
            state_in = S_PICK_OUT;
         end

         S_PICK_OUT: begin
            fin        = 1'b1;
            fin_status = STATUS_DONE;
            fin_picked = rd_data;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // completion: load the result beat, return to idle
      if (fin) begin
         state_in               = S_IDLE;
         rsp_valid_in           = 1'b1;
         rsp_in.status          = fin_status;
         rsp_in.picked_value    = fin_picked;
         rsp_in.element_count   = COUNT_W'(count_in);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      rnd_ff   <= rnd_in;
      scan_ff  <= scan_in;
      hit_ff   <= hit_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      rsp_ff   <= rsp_in;
   end

   // ---------------------------------------------------------------- assertions

   // element count never exceeds the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // a result beat is only raised as the sequencer goes idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("result strobe while busy");

   // an empty-set status always reports a zero count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_EMPTY) |-> (rsp_ff.element_count == '0))
      else $error("empty status with nonzero count");

   // picked value is zero unless the beat completed
   a_picked_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STATUS_DONE) |-> (rsp_ff.picked_value == '0))
      else $error("picked value nonzero on failed operation");

endmodule

`default_nettype wire

### rtl/rss_store.sv
// Dense value store: one write port, one read port, registered read data.
// Depends on rss_pkg for the data width and the default depth.
`default_nettype none

module rss_store
   import rss_pkg::*;
#(
   parameter int DEPTH  = CAPACITY_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### tb/rss_result_checker.sv
// Result checker for random_sample_set_core: predicts each response and compares it.
// Depends on rss_pkg for the beat types and codes; instantiated by testbench.
`default_nettype none

module rss_result_checker
   import rss_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_item,
   input  wire logic    rsp_strobe,
   input  wire rsp_type rsp_item,
   output int unsigned  mismatch_count,
   output int unsigned  awaited_count
);

   localparam int unsigned REPORT_LIMIT = 10;

   // mirror of the set: dense entries below member_total
   // (two-state counters start at zero)
   logic signed [DATA_W-1:0] member_values [CAPACITY];
   int unsigned              member_total;
   rsp_type                  awaited_results [$];
   int unsigned              errors;

   // applies one operation to the mirror, returns the response it must produce
   function automatic rsp_type apply_set_op(input req_type op);
      rsp_type     res;
      int unsigned slot;
      res  = '{status: STATUS_NOT, picked_value: '0, element_count: '0};
      slot = member_total;
      for (int unsigned i = 0; i < member_total; i++) begin
         if (member_values[i] == op.value && slot == member_total) slot = i;
      end
      case (op.kind)
         KIND_INSERT: begin
            if (slot < member_total) begin
               res.status = STATUS_NOT;
            end else if (member_total >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               member_values[member_total] = op.value;
               member_total++;
               res.status = STATUS_DONE;
            end
         end
         KIND_REMOVE: begin
            // last entry fills the hole
            if (slot < member_total) begin
               member_values[slot] = member_values[member_total - 1];
               member_total--;
               res.status = STATUS_DONE;
            end
         end
         KIND_DRAW: begin
            if (member_total == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.picked_value = member_values[32'(op.random_draw) % member_total];
               res.status       = STATUS_DONE;
            end
         end
         default: ;
      endcase
      res.element_count = COUNT_W'(member_total);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         member_total = 0;
         awaited_results.delete();
      end else begin
         if (start && !busy) awaited_results = {awaited_results, apply_set_op(req_item)};
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: unexpected response status=%0d picked=%0d count=%0d",
                           $time, rsp_item.status, rsp_item.picked_value,
                           rsp_item.element_count);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_item.status !== want.status ||
                   rsp_item.picked_value !== want.picked_value ||
                   rsp_item.element_count !== want.element_count) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d (status/picked/count)",
                              $time, want.status, want.picked_value, want.element_count,
                              rsp_item.status, rsp_item.picked_value,
                              rsp_item.element_count);
               end
            end
         end
      end
      mismatch_count <= errors;
      awaited_count  <= awaited_results.size();
   end

endmodule

`default_nettype wire

### tb/testbench.sv
// Top of the random_sample_set_core bench: clock, reset, stimulus and verdict.
// Depends on rss_pkg, random_sample_set_core and rss_result_checker.
`default_nettype none

module testbench;
   import rss_pkg::*;

   // the block ignores this code; it must answer "not done" and change nothing
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int unsigned POOL_SIZE    = 96;     // above capacity so the store can fill
   localparam int unsigned ROUNDS       = 12;
   localparam int unsigned ROUND_BEATS  = 58;
   localparam int unsigned DRAIN_CYCLES = 80;
   localparam int unsigned CYCLE_LIMIT  = 600000;

   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef enum {MODE_FILL, MODE_MIXED, MODE_DRAIN} round_mode_type;

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   req_type     req_item = '0;
   logic        busy;
   logic        rsp_strobe;
   rsp_type     rsp_item;
   int unsigned mismatch_count;
   int unsigned awaited_count;
   int unsigned cycle_count = 0;

   // sender idling for the current phase, percent
   int unsigned idle_pct = 0;

   // values the random part works on; a small pool makes removes and
   // duplicate inserts hit, a walking cursor over it fills the store fast
   logic signed [DATA_W-1:0] value_pool [POOL_SIZE];
   int unsigned              fill_cursor = 0;

   random_sample_set_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   rss_result_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_strobe     (rsp_strobe),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   always #2 clock = ~clock;

   // watchdog: a hang anywhere ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("random_sample_set_core verification failed");
         $finish;
      end
   end

   // Drives one beat and returns at the edge that accepts it (start high,
   // busy low). In idle phases start drops for a while first: mostly short
   // gaps, now and then a long one so the gap can end in any phase of the
   // block's scan. start stays high between back-to-back beats.
   task automatic send_beat(input logic [1:0] op, input logic signed [DATA_W-1:0] val,
                            input logic [RAND_W-1:0] rnd);
      int unsigned gap;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(80, 4) : $urandom_range(3, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= '{kind: op, value: val, random_draw: rnd};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // One random beat; the mode sets the operation mix. Draw words are
   // either full width or small, so both the modulo and low indexes get
   // exercised. Some removes use fresh values that are almost never present.
   task automatic random_beat(input round_mode_type mode);
      int unsigned              roll;
      int unsigned              ins_pct;
      int unsigned              rem_pct;
      logic signed [DATA_W-1:0] val;
      logic [RAND_W-1:0]        rnd;
      case (mode)
         MODE_FILL: begin
            ins_pct = 85;
            rem_pct = 4;
         end
         MODE_DRAIN: begin
            ins_pct = 10;
            rem_pct = 70;
         end
         default: begin
            ins_pct = 42;
            rem_pct = 35;
         end
      endcase
      roll = $urandom_range(99);
      val  = value_pool[$urandom_range(POOL_SIZE - 1)];
      rnd  = ($urandom_range(2) == 0) ? RAND_W'($urandom_range(130)) : RAND_W'($urandom);
      if (roll < ins_pct) begin
         if (mode == MODE_FILL && $urandom_range(9) < 7) begin
            val         = value_pool[fill_cursor];
            fill_cursor = (fill_cursor + 1) % POOL_SIZE;
         end
         send_beat(KIND_INSERT, val, rnd);
      end else if (roll < ins_pct + rem_pct) begin
         if ($urandom_range(99) < 15) val = $urandom;
         send_beat(KIND_REMOVE, val, rnd);
      end else if (roll < 97) begin
         send_beat(KIND_DRAW, $urandom, rnd);
      end else begin
         send_beat(KIND_UNUSED, $urandom, rnd);
      end
   endtask

   initial begin
      round_mode_type mode;
      value_pool[0] = VAL_MIN;
      value_pool[1] = VAL_MAX;
      value_pool[2] = '0;
      value_pool[3] = '1;
      for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- directed: empty-set cases, the unused code, value extremes ---
      send_beat(KIND_DRAW, 32'sd7, '1);              // draw on empty set
      send_beat(KIND_REMOVE, 32'sd12345, '0);        // remove on empty set
      send_beat(KIND_UNUSED, 32'sd12345, '1);        // unused kind, nothing changes
      send_beat(KIND_INSERT, VAL_MIN, '0);
      send_beat(KIND_INSERT, VAL_MAX, '0);
      send_beat(KIND_INSERT, '0, '0);
      send_beat(KIND_INSERT, '1, '0);
      send_beat(KIND_INSERT, VAL_MAX, '1);           // already present
      send_beat(KIND_DRAW, '0, '0);                  // first slot
      send_beat(KIND_DRAW, '1, '1);                  // largest draw word
      send_beat(KIND_REMOVE, 32'sd12345, '0);        // absent value
      send_beat(KIND_REMOVE, VAL_MIN, '0);           // first slot, last entry moves in
      send_beat(KIND_DRAW, '0, '0);                  // sees the moved entry
      send_beat(KIND_REMOVE, '0, '0);                // last slot, nothing to move
      send_beat(KIND_REMOVE, '1, '0);
      send_beat(KIND_REMOVE, VAL_MAX, '0);           // set empty again
      send_beat(KIND_DRAW, VAL_MAX, '1);
      send_beat(KIND_INSERT, 32'sh5555_5555, '0);    // alternating bit patterns
      send_beat(KIND_INSERT, 32'shAAAA_AAAA, '0);
      send_beat(KIND_DRAW, '0, RAND_W'(1));
      send_beat(KIND_REMOVE, 32'sh5555_5555, '0);
      send_beat(KIND_REMOVE, 32'shAAAA_AAAA, '0);

      // --- random rounds: fill to capacity, churn, drain; idling varies ---
      // sender idle phases cycle 0 / 50 / 0 / 29 percent; the receiver side
      // cannot stall, so its phases run without idling
      for (int r = 0; r < ROUNDS; r++) begin
         case (r % 4)
            1:       idle_pct = 50;
            3:       idle_pct = 29;
            default: idle_pct = 0;
         endcase
         case (r % 6)
            0, 1:    mode = MODE_FILL;
            3, 4:    mode = MODE_DRAIN;
            default: mode = MODE_MIXED;
         endcase
         for (int b = 0; b < ROUND_BEATS; b++) random_beat(mode);
      end
      start <= 1'b0;

      // the checker's count is registered and so trails the last accept
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      // catch any stray response after the last one
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_count == 0)
         $display("random_sample_set_core verification clean");
      else
         $display("random_sample_set_core verification failed");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
rtl/rss_pkg.sv
rtl/rss_store.sv
rtl/random_sample_set_core.sv
tb/rss_result_checker.sv
tb/testbench.sv
